// ===== hw/rtl/nlc_pkg.sv =====
package nlc_pkg;

   localparam int LineBufferBytesDefault = 128;

   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharHash   = 8'h23;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharNul    = 8'h00;

   localparam logic [23:0] FmtGga = 24'h474741;
   localparam logic [23:0] FmtRmc = 24'h524D43;
   localparam logic [23:0] FmtThs = 24'h544853;
   localparam logic [23:0] FmtVtg = 24'h565447;

   typedef enum logic [3:0] {
      STATUS_IGNORED   = 4'd0,
      STATUS_OVERFLOW  = 4'd1,
      STATUS_BAD_SUM   = 4'd2,
      STATUS_TOO_SHORT = 4'd3,
      STATUS_OTHER     = 4'd4,
      STATUS_GGA       = 4'd5,
      STATUS_RMC       = 4'd6,
      STATUS_THS       = 4'd7,
      STATUS_VTG       = 4'd8,
      STATUS_VERSION   = 4'd9
   } nlc_status_type;

   typedef struct packed {
      nlc_status_type status;
      logic [7:0]     computed_sum;
      logic [7:0]     received_sum;
      logic [6:0]     line_length;
      logic           receiver_up;
      logic           version_seen;
   } nlc_result_type;

   // "VERSIONA", indexed from the character after '#'
   function automatic logic [7:0] version_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h56;
         3'd1: c = 8'h45;
         3'd2: c = 8'h52;
         3'd3: c = 8'h53;
         3'd4: c = 8'h49;
         3'd5: c = 8'h4F;
         3'd6: c = 8'h4E;
         3'd7: c = 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b1, 4'(c - 8'h57)};
      end else begin
         d = 5'd0;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/nlc_line_state.sv =====
module nlc_line_state
   import nlc_pkg::*;
#(
   parameter int LINE_BUFFER_BYTES = LineBufferBytesDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           take,
   input  logic [7:0]     rx_byte,
   output logic           line_done,
   output nlc_result_type result
);

   localparam int CW = $clog2(LINE_BUFFER_BYTES);
   localparam logic [CW-1:0] LastPos = CW'(LINE_BUFFER_BYTES - 1);

   logic [CW-1:0] char_count_ff, char_count_in;
   logic          overflowed_ff, overflowed_in;
   logic [7:0]    lead_char_ff, lead_char_in;
   logic          text_ended_ff, text_ended_in;
   logic [CW-1:0] text_length_ff, text_length_in;
   logic [7:0]    running_xor_ff, running_xor_in;
   logic          star_seen_ff, star_seen_in;
   logic [15:0]   hex_chars_ff, hex_chars_in;
   logic [1:0]    hex_count_ff, hex_count_in;
   logic [23:0]   fmt_ff, fmt_in;
   logic          version_match_ff, version_match_in;
   logic          up_flag_ff, up_flag_in;
   logic          version_flag_ff, version_flag_in;

   logic          is_term;
   logic [4:0]    d0, d1;
   logic [7:0]    hex_val;
   logic [CW-1:0] pos_m1;

   assign is_term = (rx_byte == CharCr) || (rx_byte == CharLf);
   assign d0      = hex_digit(hex_chars_ff[15:8]);
   assign d1      = hex_digit(hex_chars_ff[7:0]);
   assign pos_m1  = char_count_ff - CW'(1);

   always_comb begin
      hex_val = 8'd0;
      if (d0[4]) begin
         hex_val = d1[4] ? {d0[3:0], d1[3:0]} : {4'd0, d0[3:0]};
      end
   end

   always_comb begin
      char_count_in    = char_count_ff;
      overflowed_in    = overflowed_ff;
      lead_char_in     = lead_char_ff;
      text_ended_in    = text_ended_ff;
      text_length_in   = text_length_ff;
      running_xor_in   = running_xor_ff;
      star_seen_in     = star_seen_ff;
      hex_chars_in     = hex_chars_ff;
      hex_count_in     = hex_count_ff;
      fmt_in           = fmt_ff;
      version_match_in = version_match_ff;
      up_flag_in       = up_flag_ff;
      version_flag_in  = version_flag_ff;
      line_done        = 1'b0;

      result.status       = STATUS_IGNORED;
      result.computed_sum = 8'd0;
      result.received_sum = 8'd0;
      result.line_length  = 7'(char_count_ff);
      result.receiver_up  = up_flag_ff;
      result.version_seen = version_flag_ff;

      if (take) begin
         if (!is_term) begin
            if (char_count_ff < LastPos) begin
               char_count_in = char_count_ff + CW'(1);
               if (char_count_ff >= CW'(1) && char_count_ff <= CW'(8) &&
                   rx_byte != version_char(pos_m1[2:0])) begin
                  version_match_in = 1'b0;
               end
               if (!text_ended_ff) begin
                  if (rx_byte == CharNul) begin
                     text_ended_in = 1'b1;
                  end else begin
                     text_length_in = text_length_ff + CW'(1);
                     if (char_count_ff == '0) begin
                        lead_char_in = rx_byte;
                     end else begin
                        if (!star_seen_ff) begin
                           if (rx_byte == CharStar) begin
                              star_seen_in = 1'b1;
                           end else begin
                              running_xor_in = running_xor_ff ^ rx_byte;
                           end
                        end else if (hex_count_ff < 2'd2) begin
                           hex_chars_in = {hex_chars_ff[7:0], rx_byte};
                           hex_count_in = hex_count_ff + 2'd1;
                        end
                        if (char_count_ff >= CW'(3) && char_count_ff <= CW'(5)) begin
                           fmt_in = {fmt_ff[15:0], rx_byte};
                        end
                     end
                  end
               end
            end else begin
               overflowed_in = 1'b1;
            end
         end else begin
            line_done = (char_count_ff != '0);
            if (line_done) begin
               if (overflowed_ff) begin
                  result.status = STATUS_OVERFLOW;
               end else if (lead_char_ff == CharDollar) begin
                  result.computed_sum = running_xor_ff;
                  if (hex_count_ff == 2'd2) begin
                     result.received_sum = hex_val;
                  end
                  if (!star_seen_ff || hex_count_ff != 2'd2 || hex_val != running_xor_ff) begin
                     result.status = STATUS_BAD_SUM;
                  end else if (text_length_ff < CW'(6)) begin
                     result.status = STATUS_TOO_SHORT;
                  end else begin
                     if (fmt_ff == FmtGga) begin
                        result.status = STATUS_GGA;
                     end else if (fmt_ff == FmtRmc) begin
                        result.status = STATUS_RMC;
                     end else if (fmt_ff == FmtThs) begin
                        result.status = STATUS_THS;
                     end else if (fmt_ff == FmtVtg) begin
                        result.status = STATUS_VTG;
                     end else begin
                        result.status = STATUS_OTHER;
                     end
                     if (result.status != STATUS_OTHER) begin
                        up_flag_in = 1'b1;
                     end
                  end
               end else if (lead_char_ff == CharHash) begin
                  if (version_match_ff && text_length_ff >= CW'(9)) begin
                     result.status   = STATUS_VERSION;
                     up_flag_in      = 1'b1;
                     version_flag_in = 1'b1;
                  end
               end
            end
            result.receiver_up  = up_flag_in;
            result.version_seen = version_flag_in;

            // every terminator starts a fresh line
            char_count_in    = '0;
            overflowed_in    = 1'b0;
            lead_char_in     = 8'd0;
            text_ended_in    = 1'b0;
            text_length_in   = '0;
            running_xor_in   = 8'd0;
            star_seen_in     = 1'b0;
            hex_chars_in     = 16'd0;
            hex_count_in     = 2'd0;
            fmt_in           = 24'd0;
            version_match_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff    <= '0;
         overflowed_ff    <= 1'b0;
         lead_char_ff     <= 8'd0;
         text_ended_ff    <= 1'b0;
         text_length_ff   <= '0;
         running_xor_ff   <= 8'd0;
         star_seen_ff     <= 1'b0;
         hex_chars_ff     <= 16'd0;
         hex_count_ff     <= 2'd0;
         fmt_ff           <= 24'd0;
         version_match_ff <= 1'b1;
         up_flag_ff       <= 1'b0;
         version_flag_ff  <= 1'b0;
      end else begin
         char_count_ff    <= char_count_in;
         overflowed_ff    <= overflowed_in;
         lead_char_ff     <= lead_char_in;
         text_ended_ff    <= text_ended_in;
         text_length_ff   <= text_length_in;
         running_xor_ff   <= running_xor_in;
         star_seen_ff     <= star_seen_in;
         hex_chars_ff     <= hex_chars_in;
         hex_count_ff     <= hex_count_in;
         fmt_ff           <= fmt_in;
         version_match_ff <= version_match_in;
         up_flag_ff       <= up_flag_in;
         version_flag_ff  <= version_flag_in;
      end
   end

endmodule

// ===== hw/rtl/nmea_line_checker_top.sv =====
// NMEA line checker: takes one received byte per transaction and gives one status
// transaction for each non-empty line ended by CR or LF. '$' lines are checked
// against their two-digit hex checksum and sorted by sentence type; a line starting
// with "#VERSIONA" raises version_seen. Lines longer than LINE_BUFFER_BYTES-1
// characters report overflow. Unless stalled, a byte is taken every cycle: it is
// registered, processed in a single pass against the line state, and the status
// lands in an output register, so throughput is one byte per clock while unstalled.
// Backpressure on the status side stalls the input only while a finished status is
// still waiting to be taken.
module nmea_line_checker_top
   import nlc_pkg::*;
#(
   parameter int LINE_BUFFER_BYTES = LineBufferBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_line_status,
   output logic [7:0] rsp_computed_sum,
   output logic [7:0] rsp_received_sum,
   output logic [6:0] rsp_line_length,
   output logic       rsp_receiver_up,
   output logic       rsp_version_seen
);

   logic           byte_valid_ff, byte_valid_in;
   logic [7:0]     byte_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   nlc_result_type rsp_ff;
   nlc_result_type line_result;
   logic           line_done;
   logic           stage_go;
   logic           req_fire;

   assign stage_go  = byte_valid_ff && !(rsp_valid_ff && !rsp_ready);
   assign req_ready = !byte_valid_ff || stage_go;
   assign req_fire  = req_valid && req_ready;

   assign byte_valid_in = req_fire || (byte_valid_ff && !stage_go);
   assign rsp_valid_in  = (stage_go && line_done) || (rsp_valid_ff && !rsp_ready);

   nlc_line_state #(
      .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
   ) u_line_state (
      .clock    (clock),
      .reset    (reset),
      .take     (stage_go),
      .rx_byte  (byte_ff),
      .line_done(line_done),
      .result   (line_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_rx_byte;
      end
      if (stage_go && line_done) begin
         rsp_ff <= line_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_status  = rsp_ff.status;
   assign rsp_computed_sum = rsp_ff.computed_sum;
   assign rsp_received_sum = rsp_ff.received_sum;
   assign rsp_line_length  = rsp_ff.line_length;
   assign rsp_receiver_up  = rsp_ff.receiver_up;
   assign rsp_version_seen = rsp_ff.version_seen;

endmodule
